/* rtl/waypoint_turn_drive_controller_assert.svh */
// Assertion helpers for the waypoint controller.
`ifndef WAYPOINT_TURN_DRIVE_CONTROLLER_ASSERT_SVH
`define WAYPOINT_TURN_DRIVE_CONTROLLER_ASSERT_SVH

// Implication checked on every rising clock edge, outside reset.
`define WTD_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: label failed");

// Property that must hold on the next edge.
`define WTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: label failed");

`endif

/* rtl/wtdc_pkg.sv */
package wtdc_pkg;

   localparam int WAYPOINT_DEPTH_DEF = 64;
   localparam int CORDIC_STEPS_DEF   = 16;
   localparam int HEADING_TOL        = 730;
   localparam int ANGLE_TABLE_LEN    = 24;

   localparam logic [2:0] REG_DRIVE_GAIN = 3'd0;
   localparam logic [2:0] REG_STEER_GAIN = 3'd1;
   localparam logic [2:0] REG_TURN_GAIN  = 3'd2;
   localparam logic [2:0] REG_SPEED_LO   = 3'd3;
   localparam logic [2:0] REG_SPEED_HI   = 3'd4;
   localparam logic [2:0] REG_MIN_TURN   = 3'd5;
   localparam logic [2:0] REG_MAX_TURN   = 3'd6;
   localparam logic [2:0] REG_POS_TOL    = 3'd7;

   localparam logic [1:0] PHASE_TURN  = 2'd0;
   localparam logic [1:0] PHASE_DRIVE = 2'd1;
   localparam logic [1:0] PHASE_EMPTY = 2'd2;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_FETCH  = 8'b0000_0010,
      ST_DIFF   = 8'b0000_0100,
      ST_CORDIC = 8'b0000_1000,
      ST_ALPHA  = 8'b0001_0000,
      ST_SQRT   = 8'b0010_0000,
      ST_MUL    = 8'b0100_0000,
      ST_OUT    = 8'b1000_0000
   } state_type;

   function automatic logic [31:0] atan_entry(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051E;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2F;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2FA;
         5'd15: r = 32'h0000517D;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A30;
         5'd19: r = 32'h00000518;
         5'd20: r = 32'h0000028C;
         5'd21: r = 32'h00000146;
         5'd22: r = 32'h000000A3;
         5'd23: r = 32'h00000051;
         default: r = 32'h0;
      endcase
      return r;
   endfunction

endpackage

/* rtl/waypoint_turn_drive_controller.sv */
// Waypoint follower. Load beats (tuser mode=1) append a point to a ring of
// WAYPOINT_DEPTH entries and return nothing; a load flagged first_point empties
// the ring, goes back to turning and is itself dropped. Each pose beat (mode=0)
// returns one command beat. The block takes one beat at a time, and only while
// idle with its output register empty or being read in that same cycle, so a
// result left waiting stalls the next beat, loads included. A load is taken
// in the idle state. A pose beat holds the block until its result is
// registered: with an empty ring it returns from fetch to idle; while turning
// it runs fetch, difference, the CORDIC steps on the shift-add unit, alpha,
// multiply and output; while driving it adds the 21 square-root steps before
// the multiply. With the pose on the waypoint the CORDIC is skipped. The
// waypoint memory needs no clearing.
`include "waypoint_turn_drive_controller_assert.svh"

module waypoint_turn_drive_controller
   import wtdc_pkg::*;
#(
   parameter int WAYPOINT_DEPTH = WAYPOINT_DEPTH_DEF,
   parameter int CORDIC_STEPS   = CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // pos_x[19:0], pos_y[39:20], heading[55:40]
   input  logic [1:0]  req_tuser,   // mode[0], first_point[1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // drive_speed[15:0], turn_rate[31:16], phase[33:32]
   output logic        rsp_tuser,   // path_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;
   localparam int CW = $clog2(WAYPOINT_DEPTH + 1);
   localparam int SW = $clog2(CORDIC_STEPS + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(WAYPOINT_DEPTH);
   localparam logic [AW-1:0] LAST_IDX = AW'(WAYPOINT_DEPTH - 1);
   localparam logic signed [15:0] TOL16 = 16'(HEADING_TOL);

   // configuration
   logic [15:0] drive_gain_ff, steer_gain_ff, turn_gain_ff, speed_lo_ff, speed_hi_ff;
   logic [14:0] min_turn_ff, max_turn_ff;
   logic [15:0] pos_tol_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         drive_gain_ff <= 16'd205;
         steer_gain_ff <= 16'd51;
         turn_gain_ff  <= 16'd256;
         speed_lo_ff   <= 16'd614;
         speed_hi_ff   <= 16'd1024;
         min_turn_ff   <= 15'd4096;
         max_turn_ff   <= 15'd8192;
         pos_tol_ff    <= 16'd205;
      end else if (csr_valid) begin
         case (csr_index)
            REG_DRIVE_GAIN: drive_gain_ff <= csr_data;
            REG_STEER_GAIN: steer_gain_ff <= csr_data;
            REG_TURN_GAIN:  turn_gain_ff  <= csr_data;
            REG_SPEED_LO:   speed_lo_ff   <= csr_data;
            REG_SPEED_HI:   speed_hi_ff   <= csr_data;
            REG_MIN_TURN:   min_turn_ff   <= csr_data[14:0];
            REG_MAX_TURN:   max_turn_ff   <= csr_data[14:0];
            REG_POS_TOL:    pos_tol_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // waypoint memory
   logic [39:0] wp_mem [WAYPOINT_DEPTH];
   logic [39:0] wp_rd_ff;
   logic        wp_we;
   logic [AW-1:0] wp_wa;

   // control state
   state_type   state_ff;
   logic [AW-1:0] rd_idx_ff;
   logic [CW-1:0] count_ff;
   logic        drop_ff;
   logic        drive_ph_ff;

   // working registers
   logic signed [19:0] px_ff, py_ff;
   logic [15:0] hdg_ff;
   logic signed [20:0] dx_ff, dy_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic [31:0] z_ff;
   logic [SW-1:0] step_ff;
   logic [41:0] sq_v_ff;
   logic [41:0] sq_res_ff;
   logic [41:0] sq_bit_ff;
   logic signed [15:0] alpha_ff;
   logic        arrive_ff;
   logic [20:0] dist_ff;
   logic        mulsel_ff;   // 0: speed and steer-rate products, 1: turn-rate product only
   logic [36:0] prod_s_ff;
   logic signed [32:0] prod_r_ff;

   // output register
   logic        rsp_valid_ff;
   logic [15:0] o_speed_ff;
   logic [15:0] o_rate_ff;
   logic [1:0]  o_phase_ff;
   logic        o_done_ff;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, o_phase_ff, o_rate_ff, o_speed_ff};
   assign rsp_tuser  = o_done_ff;

   logic acc;
   assign acc = req_tvalid && req_tready;
   logic in_mode, in_first;
   assign in_mode  = req_tuser[0];
   assign in_first = req_tuser[1];

   // load handling
   logic [CW-1:0] load_cnt;
   logic          load_drop;
   logic [AW:0]   wsum;
   assign load_cnt  = in_first ? '0 : count_ff;
   assign load_drop = in_first || drop_ff;
   always_comb begin
      wsum = {1'b0, (in_first ? '0 : rd_idx_ff)} + (AW+1)'(load_cnt);
      if (wsum >= (AW+1)'(WAYPOINT_DEPTH)) wsum = wsum - (AW+1)'(WAYPOINT_DEPTH);
   end
   assign wp_wa = wsum[AW-1:0];
   assign wp_we = acc && in_mode && !load_drop && (load_cnt < DEPTH_C);

   always_ff @(posedge clock) begin
      if (wp_we) wp_mem[wp_wa] <= req_tdata[39:0];
      wp_rd_ff <= wp_mem[rd_idx_ff];
   end

   // shift-add unit for the CORDIC steps
   logic signed [33:0] sh_x, sh_y;
   logic [4:0] stp5;
   assign stp5 = 5'(step_ff);
   assign sh_x = cx_ff >>> stp5;
   assign sh_y = cy_ff >>> stp5;

   // rate shaping
   function automatic logic [15:0] shape(input logic signed [32:0] prod,
                                         input logic [14:0] lo, input logic [14:0] hi);
      logic [32:0] mag;
      logic [24:0] m8;
      logic [14:0] r;
      logic [15:0] res;
      mag = prod[32] ? 33'(-prod) : 33'(prod);
      m8  = mag[32:8];
      r   = (m8 > 25'(hi)) ? hi : m8[14:0];
      if (r < lo) r = lo;
      res = (prod > 0) ? {1'b0, r} : 16'(-{1'b0, r});
      return res;
   endfunction

   logic [31:0] a_diff;
   assign a_diff = z_ff - {hdg_ff, 16'd0};
   logic [15:0] alpha_n;
   assign alpha_n = 16'((a_diff + 32'h8000) >> 16);

   logic signed [21:0] tolp;
   assign tolp = {6'd0, pos_tol_ff};
   logic sq_ge;
   logic [41:0] sq_sum;
   assign sq_sum = sq_res_ff + sq_bit_ff;
   assign sq_ge  = sq_v_ff >= sq_sum;

   logic [36:0] sp_sh;
   assign sp_sh = prod_s_ff >> 8;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_idx_ff    <= '0;
         count_ff     <= '0;
         drop_ff      <= 1'b0;
         drive_ph_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               // a waiting result only ever sits here
               if (rsp_valid_ff && rsp_tready) rsp_valid_ff <= 1'b0;
               if (acc) begin
                  if (in_mode) begin
                     if (in_first) begin
                        rd_idx_ff   <= '0;
                        drive_ph_ff <= 1'b0;
                     end
                     drop_ff  <= 1'b0;
                     count_ff <= (!load_drop && load_cnt < DEPTH_C) ?
                                 load_cnt + CW'(1) : load_cnt;
                  end else begin
                     px_ff  <= req_tdata[19:0];
                     py_ff  <= req_tdata[39:20];
                     hdg_ff <= req_tdata[55:40];
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               // memory read registered from rd_idx_ff
               if (count_ff == '0) begin
                  o_speed_ff <= '0; o_rate_ff <= '0; o_phase_ff <= PHASE_EMPTY;
                  o_done_ff <= 1'b0; rsp_valid_ff <= 1'b1;
                  state_ff <= ST_IDLE;
               end else state_ff <= ST_DIFF;
            end
            ST_DIFF: begin
               logic signed [20:0] dxn, dyn;
               dxn = 21'(signed'(wp_rd_ff[19:0])) - 21'(px_ff);
               dyn = 21'(signed'(wp_rd_ff[39:20])) - 21'(py_ff);
               dx_ff <= dxn;
               dy_ff <= dyn;
               if (dxn < 0) begin
                  cx_ff <= -(34'(dxn) <<< 10);
                  cy_ff <= -(34'(dyn) <<< 10);
                  z_ff  <= 32'h8000_0000;
               end else begin
                  cx_ff <= 34'(dxn) <<< 10;
                  cy_ff <= 34'(dyn) <<< 10;
                  z_ff  <= '0;
               end
               step_ff  <= '0;
               state_ff <= (dxn == 0 && dyn == 0) ? ST_ALPHA : ST_CORDIC;
            end
            ST_CORDIC: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + sh_y;
                  cy_ff <= cy_ff - sh_x;
                  z_ff  <= z_ff + atan_entry(stp5);
               end else begin
                  cx_ff <= cx_ff - sh_y;
                  cy_ff <= cy_ff + sh_x;
                  z_ff  <= z_ff - atan_entry(stp5);
               end
               step_ff <= step_ff + SW'(1);
               if (step_ff == SW'(CORDIC_STEPS - 1)) state_ff <= ST_ALPHA;
            end
            ST_ALPHA: begin
               alpha_ff  <= alpha_n;
               arrive_ff <= (22'(dx_ff) > -tolp) && (22'(dx_ff) < tolp) &&
                            (22'(dy_ff) > -tolp) && (22'(dy_ff) < tolp);
               sq_v_ff   <= 42'(dx_ff) * 42'(dx_ff) + 42'(dy_ff) * 42'(dy_ff);
               sq_res_ff <= '0;
               sq_bit_ff <= 42'd1 << 40;
               if (!drive_ph_ff) begin
                  prod_r_ff <= 33'(signed'(alpha_n)) * 33'(signed'({1'b0, turn_gain_ff}));
                  mulsel_ff <= 1'b1;
                  state_ff  <= ST_MUL;
               end else begin
                  mulsel_ff <= 1'b0;
                  state_ff  <= ST_SQRT;
               end
            end
            ST_SQRT: begin
               if (sq_ge) begin
                  sq_v_ff   <= sq_v_ff - sq_sum;
                  sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
               end else sq_res_ff <= sq_res_ff >> 1;
               sq_bit_ff <= sq_bit_ff >> 2;
               if (sq_bit_ff[0]) begin
                  dist_ff  <= sq_ge ? 21'((sq_res_ff >> 1) + sq_bit_ff)
                                    : 21'(sq_res_ff >> 1);
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               if (!mulsel_ff) begin
                  prod_s_ff <= 37'(drive_gain_ff) * 37'(dist_ff);
                  prod_r_ff <= 33'(signed'(alpha_ff)) * 33'(signed'({1'b0, steer_gain_ff}));
               end
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               logic [15:0] sp, rt;
               logic [1:0]  ph;
               logic        dn;
               sp = '0;
               rt = '0;
               dn = 1'b0;
               ph = drive_ph_ff ? PHASE_DRIVE : PHASE_TURN;
               if (!drive_ph_ff) begin
                  if (alpha_ff > -TOL16 && alpha_ff < TOL16) begin
                     drive_ph_ff <= 1'b1;
                     ph = PHASE_DRIVE;
                  end else rt = shape(prod_r_ff, min_turn_ff, max_turn_ff);
               end else if (arrive_ff) begin
                  rd_idx_ff   <= (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + AW'(1);
                  count_ff    <= count_ff - CW'(1);
                  drive_ph_ff <= 1'b0;
                  ph = (count_ff == CW'(1)) ? PHASE_EMPTY : PHASE_TURN;
                  dn = (count_ff == CW'(1));
               end else begin
                  sp = (sp_sh > 37'(speed_hi_ff)) ? speed_hi_ff : sp_sh[15:0];
                  if (sp < speed_lo_ff) sp = speed_lo_ff;
                  rt = shape(prod_r_ff, 15'd0, max_turn_ff);
               end
               o_speed_ff   <= sp;
               o_rate_ff    <= rt;
               o_phase_ff   <= ph;
               o_done_ff    <= dn;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `WTD_ASSERT_IMP(a_count_range, clock, reset, 1'b1, count_ff <= DEPTH_C)
   `WTD_ASSERT_IMP(a_busy_no_ready, clock, reset, state_ff != ST_IDLE, !req_tready)
   `WTD_ASSERT_NEXT(a_pose_starts, clock, reset, acc && !in_mode, state_ff == ST_FETCH)
   `WTD_ASSERT_IMP(a_rsp_idle, clock, reset, rsp_valid_ff, state_ff == ST_IDLE)

endmodule

/* verif/tb_waypoint_turn_drive_controller.sv */
`timescale 1ns / 100ps

module tb_waypoint_turn_drive_controller;
   import wtdc_pkg::*;

   localparam int RING = 64;

   typedef struct packed {
      logic [15:0] speed;
      logic [15:0] rate;
      logic [1:0]  phase;
      logic        done;
   } command_type;

   class scoreboard_type;
      logic signed [19:0] ring_x[RING];
      logic signed [19:0] ring_y[RING];
      int unsigned rd_ptr;
      int unsigned pending;
      bit          skip_load;
      bit          driving;
      int unsigned drive_gain, steer_gain, turn_gain, speed_lo, speed_hi;
      int unsigned min_turn, max_turn, pos_tol;
      command_type cmd_q[$];
      int          errors;

      function new();
         rd_ptr = 0; pending = 0; skip_load = 0; driving = 0; errors = 0;
         drive_gain = 205; steer_gain = 51; turn_gain = 256;
         speed_lo = 614; speed_hi = 1024;
         min_turn = 4096; max_turn = 8192; pos_tol = 205;
      endfunction

      function void set_reg(logic [2:0] idx, logic [15:0] v);
         case (idx)
            REG_DRIVE_GAIN: drive_gain = v;
            REG_STEER_GAIN: steer_gain = v;
            REG_TURN_GAIN:  turn_gain  = v;
            REG_SPEED_LO:   speed_lo   = v;
            REG_SPEED_HI:   speed_hi   = v;
            REG_MIN_TURN:   min_turn   = v[14:0];
            REG_MAX_TURN:   max_turn   = v[14:0];
            REG_POS_TOL:    pos_tol    = v;
            default: ;
         endcase
      endfunction

      static function logic [31:0] arctan_step(int i);
         logic [31:0] tab[16] = '{
            32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
            32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
            32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
            32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D};
         return tab[i];
      endfunction

      static function logic [31:0] bearing_to(longint dx, longint dy);
         longint x, y, t;
         logic [31:0] z;
         if (dx == 0 && dy == 0) return 32'h0;
         x = dx * 1024; y = dy * 1024; z = 32'h0;
         if (x < 0) begin
            x = -x; y = -y; z = 32'h80000000;
         end
         for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
               t = x + (y >>> i); y = y - (x >>> i); z = z + arctan_step(i);
            end else begin
               t = x - (y >>> i); y = y + (x >>> i); z = z - arctan_step(i);
            end
            x = t;
         end
         return z;
      endfunction

      static function longint unsigned root_floor(longint unsigned v);
         longint unsigned r, b;
         r = 0; b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v = v - (r + b); r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
         return r;
      endfunction

      static function longint limit_rate(longint alpha, int unsigned gain,
                                         int unsigned lo, int unsigned hi);
         longint prod, mag;
         prod = alpha * longint'(gain);
         mag = (prod < 0 ? -prod : prod) >> 8;
         if (mag > hi) mag = hi;
         if (mag < lo) mag = lo;
         return prod > 0 ? mag : -mag;
      endfunction

      // heading that points along the bearing from (px, py) to the current waypoint
      function logic [15:0] aim_heading(logic signed [19:0] px, logic signed [19:0] py);
         logic [31:0] b;
         b = bearing_to(longint'(ring_x[rd_ptr]) - px, longint'(ring_y[rd_ptr]) - py);
         b = b + 32'h8000;
         return b[31:16];
      endfunction

      function void note_item(logic mode, logic first, logic signed [19:0] px,
                              logic signed [19:0] py, logic [15:0] hdg);
         command_type c;
         longint dx, dy, alpha, speed, rate, tol;
         logic [31:0] a;
         longint unsigned sp;
         if (mode) begin
            if (first) begin
               pending = 0; rd_ptr = 0; driving = 0; skip_load = 1;
            end
            if (skip_load) begin
               skip_load = 0;
            end else if (pending < RING) begin
               ring_x[(rd_ptr + pending) % RING] = px;
               ring_y[(rd_ptr + pending) % RING] = py;
               pending++;
            end
            return;
         end
         speed = 0; rate = 0; c.done = 0;
         if (pending != 0) begin
            dx = longint'(ring_x[rd_ptr]) - px;
            dy = longint'(ring_y[rd_ptr]) - py;
            a = bearing_to(dx, dy) - {hdg, 16'h0};
            a = a + 32'h8000;
            alpha = longint'($signed(a[31:16]));
            if (!driving) begin
               if (alpha > -HEADING_TOL && alpha < HEADING_TOL) driving = 1;
               else rate = limit_rate(alpha, turn_gain, min_turn, max_turn);
            end else begin
               tol = pos_tol;
               if (dx > -tol && dx < tol && dy > -tol && dy < tol) begin
                  rd_ptr = (rd_ptr + 1) % RING;
                  pending--;
                  driving = 0;
                  if (pending == 0) c.done = 1;
               end else begin
                  sp = (longint'(drive_gain) * root_floor(dx * dx + dy * dy)) >> 8;
                  if (sp > speed_hi) sp = speed_hi;
                  if (sp < speed_lo) sp = speed_lo;
                  speed = sp;
                  rate = limit_rate(alpha, steer_gain, 0, max_turn);
               end
            end
         end
         c.speed = speed[15:0];
         c.rate  = rate[15:0];
         c.phase = pending == 0 ? PHASE_EMPTY : (driving ? PHASE_DRIVE : PHASE_TURN);
         cmd_q.push_back(c);
      endfunction

      function void check_result(logic [39:0] data, logic done);
         command_type e;
         if (cmd_q.size() == 0) begin
            $display("%0t: unexpected command beat, expected none, actual %h/%b",
                     $time, data, done);
            errors++;
            return;
         end
         e = cmd_q.pop_front();
         if (data[15:0] !== e.speed) begin
            $display("%0t: drive_speed expected %0d actual %0d", $time, e.speed, data[15:0]);
            errors++;
         end
         if (data[31:16] !== e.rate) begin
            $display("%0t: turn_rate expected %0d actual %0d", $time,
                     $signed(e.rate), $signed(data[31:16]));
            errors++;
         end
         if (data[33:32] !== e.phase) begin
            $display("%0t: phase expected %0d actual %0d", $time, e.phase, data[33:32]);
            errors++;
         end
         if (done !== e.done) begin
            $display("%0t: path_done expected %b actual %b", $time, e.done, done);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;   // pos_x[19:0], pos_y[39:20], heading[55:40]
   logic [1:0]  req_tuser;   // mode[0], first_point[1]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // drive_speed[15:0], turn_rate[31:16], phase[33:32]
   logic        rsp_tuser;   // path_done
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   scoreboard_type sb = new();
   int          sent;
   bit          idle_allowed;

   waypoint_turn_drive_controller i_dut (.*);

   always begin
      clock = 1'b1; #4;
      clock = 1'b0; #4;
   end

   initial begin
      #3_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic send(logic mode, logic first, logic signed [19:0] px,
                       logic signed [19:0] py, logic [15:0] hdg);
      int gap;
      gap = idle_allowed ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {hdg, py, px};
      req_tuser  <= {first, mode};
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, first, px, py, hdg);
      sent++;
   endtask

   task automatic pose(logic signed [19:0] px, logic signed [19:0] py, logic [15:0] hdg);
      send(1'b0, 1'b0, px, py, hdg);
   endtask

   task automatic load(logic first, logic signed [19:0] px, logic signed [19:0] py);
      send(1'b1, first, px, py, 16'($urandom));
   endtask

   // wait until the block has drained before touching its registers
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.cmd_q.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] vals[8]);
      for (int i = 0; i < 8; i++) begin
         csr_valid <= 1'b1;
         csr_index <= 3'(i);
         csr_data  <= vals[i];
         do @(posedge clock); while (!csr_ready);
         sb.set_reg(3'(i), vals[i]);
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [19:0] near(logic signed [19:0] c);
      int off;
      off = $signed($urandom_range(0, 1 << $urandom_range(2, 18))) *
            ($urandom_range(0, 1) ? 1 : -1);
      return 20'(int'(c) + off);
   endfunction

   // poses that follow the path, so the block walks through turn, drive and arrival
   task automatic guided_pose();
      logic signed [19:0] px, py, wx, wy;
      int t;
      if (sb.pending == 0 || $urandom_range(0, 19) == 0) begin
         pose(20'($urandom), 20'($urandom), 16'($urandom));
         return;
      end
      wx = sb.ring_x[sb.rd_ptr]; wy = sb.ring_y[sb.rd_ptr];
      px = near(wx); py = near(wy);
      if (sb.driving && sb.pos_tol > 0 && $urandom_range(0, 2) == 0) begin
         t = sb.pos_tol > 20000 ? 20000 : sb.pos_tol - 1;
         px = 20'(int'(wx) + $signed($urandom_range(0, 2 * t)) - t);
         py = 20'(int'(wy) + $signed($urandom_range(0, 2 * t)) - t);
      end
      if ($urandom_range(0, 3) == 0)
         pose(px, py, 16'($urandom));
      else
         pose(px, py, sb.aim_heading(px, py) + 16'($signed($urandom_range(0, 1200)) - 600));
   endtask

   task automatic random_run(int count);
      int stop;
      stop = sent + count;
      while (sent < stop) begin
         if ($urandom_range(0, 9) == 0) begin
            if ($urandom_range(0, 9) < 3) load(1'b1, 20'($urandom), 20'($urandom));
            load(1'b0, 20'($signed($urandom_range(0, 524288)) - 262144),
                 20'($signed($urandom_range(0, 524288)) - 262144));
         end else begin
            guided_pose();
         end
      end
   endtask

   // receiver: random stalls, and one long hold-off so the block backs up
   initial begin
      int gap, beats;
      beats = 0;
      rsp_tready <= 1'b0;
      @(negedge reset);
      forever begin
         gap = idle_allowed ? $urandom_range(0, 9) : 0;
         if (beats == 150) gap = 400;
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_result(rsp_tdata, rsp_tuser);
         beats++;
      end
   end

   initial begin
      logic [15:0] regs[8];
      logic signed [19:0] px, py;
      int waited;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= REG_DRIVE_GAIN;
      csr_data   <= '0;
      sent = 0;
      idle_allowed = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ring, extremes, arrival, zero offset, full ring
      pose(20'sd0, 20'sd0, 16'h0);
      load(1'b1, 20'h7FFFF, 20'h80000);
      load(1'b0, 20'h7FFFF, 20'h80000);
      load(1'b0, 20'sd0, 20'sd0);
      pose(20'h80000, 20'h7FFFF, 16'h7FFF);
      pose(20'h80000, 20'h7FFFF, 16'h8000);
      pose(20'h80000, 20'h7FFFF, sb.aim_heading(20'h80000, 20'h7FFFF));
      pose(20'h80000, 20'h7FFFF, 16'h0);
      pose(20'h7FFF0, 20'h80010, 16'h0);
      pose(20'sd0, 20'sd0, 16'h8000);
      pose(20'sd0, 20'sd0, 16'h0);
      pose(20'sd0, 20'sd0, 16'h0);
      pose(20'sd0, 20'sd0, 16'h0);
      load(1'b1, 20'sd5, 20'sd5);
      for (int i = 0; i < 66; i++) load(1'b0, 20'(i * 1000), 20'(-i * 777));
      pose(20'sd100, 20'sd100, 16'h4000);
      idle_allowed = 1'b1;
      random_run(120);
      settle();

      regs = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0, 16'h7FFF, 16'h0, 16'hFFFF};
      write_regs(regs);
      random_run(100);
      settle();

      regs = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 16'h7FFF, 16'h0};
      write_regs(regs);
      random_run(80);
      settle();

      regs = '{16'd205, 16'd51, 16'd256, 16'd614, 16'd1024, 16'd4096, 16'd8192, 16'd205};
      for (int i = 0; i < 8; i++) regs[i] = 16'($urandom_range(0, 3000));
      write_regs(regs);
      random_run(100);
      settle();

      regs = '{16'd205, 16'd51, 16'd256, 16'd614, 16'd1024, 16'd4096, 16'd8192, 16'd205};
      write_regs(regs);
      random_run(120);
      req_tvalid <= 1'b0;

      waited = 0;
      while (sb.cmd_q.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (100) @(posedge clock);
      if (sb.cmd_q.size() != 0) begin
         $display("%0t: %0d command beats never arrived, expected %0d actual 0",
                  $time, sb.cmd_q.size(), sb.cmd_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
